### sv/ppdb_pkg.sv
// Shared types and constants for the projected pixel depth/blend block.
// Used by the controller, the datapath and the top level; no dependencies.
package ppdb_pkg;

	localparam int MAX_WIDTH   = 256;
	localparam int MAX_HEIGHT  = 256;
	localparam int STORE_WORDS = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W      = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
	localparam int COL_W       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_W       = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

	localparam int DIM_W   = 9;
	localparam int SCALE_W = 16;
	localparam int CFG_W   = 16;
	localparam int COORD_W = 32;
	localparam int PIX_W   = 32;
	localparam int IDX_W   = 16;

	// Projection numerator and its magnitude.
	localparam int NUM_W      = 50;
	localparam int MAG_W      = 49;
	localparam int DIV_STEPS  = MAG_W;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

	localparam logic signed [COORD_W-1:0] NEAR_LIMIT = 32'sd6553;

	localparam logic [1:0] ST_WRITTEN = 2'd0;
	localparam logic [1:0] ST_NEAR    = 2'd1;
	localparam logic [1:0] ST_OFF     = 2'd2;
	localparam logic [1:0] ST_HIDDEN  = 2'd3;

	localparam logic [1:0] CFG_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_SCALE  = 2'd2;
	localparam logic [1:0] CFG_DEPTH  = 2'd3;

	typedef struct packed {
		logic clr;
		logic load_in;
		logic mul;
		logic sum;
		logic div_init;
		logic div_step;
		logic idx;
		logic test;
		logic commit;
		logic res_load;
	} ppdb_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic near;
		logic off;
		logic hidden;
	} ppdb_stat_t;

endpackage

### sv/projected_pixel_depth_blend_top.sv
// Top level of the projected pixel depth/blend block: configuration registers,
// controller and datapath. Depends on ppdb_pkg, ppdb_ctrl and ppdb_dp.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid/in_stall    x_pos y_pos z_depth red green blue alpha
//   out      source     out_valid/out_stall  status pixel_index pixel_value
//   cfg      sink       cfg_we               cfg_index cfg_data
//
// An on-surface point passes multiply, sum, divider setup, the 49-step restoring
// divider that forms the column and row, index, store read, depth test and blend.
// A too-near point goes straight to the result; an off-surface one after the index.
// After reset a clearing pass over all 65536 words fills the frame store with zero
// and the depth store with the farthest depth; no request is accepted meanwhile,
// while configuration writes are taken at once.
// The result sits in an output register: a stalled result holds, and a new
// request is taken as soon as the block is back in idle.
module projected_pixel_depth_blend_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [ppdb_pkg::COORD_W-1:0] x_pos,
	input  logic signed [ppdb_pkg::COORD_W-1:0] y_pos,
	input  logic signed [ppdb_pkg::COORD_W-1:0] z_depth,
	input  logic [7:0]                          red,
	input  logic [7:0]                          green,
	input  logic [7:0]                          blue,
	input  logic [7:0]                          alpha,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [1:0]                          status,
	output logic [ppdb_pkg::IDX_W-1:0]          pixel_index,
	output logic [ppdb_pkg::PIX_W-1:0]          pixel_value,
	input  logic                                cfg_we,
	input  logic [1:0]                          cfg_index,
	input  logic [ppdb_pkg::CFG_W-1:0]          cfg_data
);
	import ppdb_pkg::*;

	logic [DIM_W-1:0]   width_q;
	logic [DIM_W-1:0]   height_q;
	logic [SCALE_W-1:0] scale_q;
	logic               depth_en_q;
	ppdb_cmd_t          cmd;
	ppdb_stat_t         stat;

	// Configuration registers; each write keeps only the register's own bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= DIM_W'(256);
			height_q   <= DIM_W'(256);
			scale_q    <= SCALE_W'(256);
			depth_en_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WIDTH:  width_q    <= cfg_data[DIM_W-1:0];
				CFG_HEIGHT: height_q   <= cfg_data[DIM_W-1:0];
				CFG_SCALE:  scale_q    <= cfg_data[SCALE_W-1:0];
				CFG_DEPTH:  depth_en_q <= cfg_data[0];
				default:    depth_en_q <= depth_en_q;
			endcase
		end
	end

	// The controller walks each request through multiply, divide, store read,
	// depth test and blend, and owns the result valid.
	ppdb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	// The datapath holds both stores and the result register.
	ppdb_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.x_pos        (x_pos),
		.y_pos        (y_pos),
		.z_depth      (z_depth),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.alpha        (alpha),
		.cfg_width    (width_q),
		.cfg_height   (height_q),
		.cfg_scale    (scale_q),
		.cfg_depth_en (depth_en_q),
		.status       (status),
		.pixel_index  (pixel_index),
		.pixel_value  (pixel_value)
	);
endmodule

### sv/ppdb_ram.sv
// Generic single-write, single-read memory with a registered read port.
// No dependencies.
module ppdb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

### sv/ppdb_ctrl.sv
// Sequencing state machine for the projected pixel depth/blend block.
// Depends on ppdb_pkg for the command and status structs.
module ppdb_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	output ppdb_pkg::ppdb_cmd_t  cmd,
	input  ppdb_pkg::ppdb_stat_t stat
);
	import ppdb_pkg::*;

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_MUL   = 4'd2;
	localparam logic [3:0] S_SUM   = 4'd3;
	localparam logic [3:0] S_DIVI  = 4'd4;
	localparam logic [3:0] S_DIV   = 4'd5;
	localparam logic [3:0] S_IDX   = 4'd6;
	localparam logic [3:0] S_RD    = 4'd7;
	localparam logic [3:0] S_TEST  = 4'd8;
	localparam logic [3:0] S_BLEND = 4'd9;
	localparam logic [3:0] S_FIN   = 4'd10;

	logic [3:0]           state_q, state_d;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic                 out_valid_q;
	logic                 accept;
	logic                 can_load;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign can_load  = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (stat.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) begin
					cmd.load_in = 1'b1;
					state_d = stat.near ? S_FIN : S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_SUM;
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				state_d = S_DIVI;
			end
			S_DIVI: begin
				cmd.div_init = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) state_d = S_IDX;
			end
			S_IDX: begin
				cmd.idx = 1'b1;
				state_d = stat.off ? S_FIN : S_RD;
			end
			S_RD: begin
				state_d = S_TEST;
			end
			S_TEST: begin
				cmd.test = 1'b1;
				state_d = stat.hidden ? S_FIN : S_BLEND;
			end
			S_BLEND: begin
				cmd.commit = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (can_load) begin
					cmd.res_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DIVI) begin
				div_cnt_q <= '0;
			end else if (state_q == S_DIV) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef ASSERT_OFF
	a_fin_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && out_valid_q && out_stall) |=> (state_q == S_FIN))
		else $error("result finished while previous result still stalled");
	a_clear_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR && !stat.clr_done) |=> (state_q == S_CLEAR))
		else $error("clearing pass left early");
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (div_cnt_q < DIV_CNT_W'(DIV_STEPS)))
		else $error("divider step count overran");
	a_load_new: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |=> out_valid_q)
		else $error("loaded result not presented");
`endif
endmodule

### sv/ppdb_dp.sv
// Datapath: projection multipliers, two restoring dividers, depth test,
// alpha blend and the frame/depth stores. Depends on ppdb_pkg and ppdb_ram.
module ppdb_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ppdb_pkg::ppdb_cmd_t                  cmd,
	output ppdb_pkg::ppdb_stat_t                 stat,
	input  logic signed [ppdb_pkg::COORD_W-1:0]  x_pos,
	input  logic signed [ppdb_pkg::COORD_W-1:0]  y_pos,
	input  logic signed [ppdb_pkg::COORD_W-1:0]  z_depth,
	input  logic [7:0]                           red,
	input  logic [7:0]                           green,
	input  logic [7:0]                           blue,
	input  logic [7:0]                           alpha,
	input  logic [ppdb_pkg::DIM_W-1:0]           cfg_width,
	input  logic [ppdb_pkg::DIM_W-1:0]           cfg_height,
	input  logic [ppdb_pkg::SCALE_W-1:0]         cfg_scale,
	input  logic                                 cfg_depth_en,
	output logic [1:0]                           status,
	output logic [ppdb_pkg::IDX_W-1:0]           pixel_index,
	output logic [ppdb_pkg::PIX_W-1:0]           pixel_value
);
	import ppdb_pkg::*;

	localparam int RW_W = ROW_W + DIM_W;

	logic signed [COORD_W-1:0] x_q, y_q, z_q;
	logic [7:0]                col_q [3];
	logic [7:0]                a_q;

	logic [DIM_W-1:0] w_eff, h_eff;
	logic signed [MAG_W-1:0] xs_s1, ys_s1, wz_s1, hz_s1;
	logic signed [NUM_W-1:0] numc_s2, numr_s2;

	logic                negc_q, negr_q;
	logic [COORD_W-1:0]  remc_q, remr_q;
	logic [MAG_W-1:0]    dvdc_q, dvdr_q;
	logic [COORD_W:0]    remc_sh, remr_sh, z_ext;
	logic                gec, ger;

	logic                in_col, in_row;
	logic [COL_W-1:0]    col_c;
	logic [ROW_W-1:0]    row_c;
	logic [RW_W-1:0]     rw_c;
	logic [ADDR_W-1:0]   idx_q, idx_c;

	logic [ADDR_W-1:0]   clr_cnt_q;
	logic [PIX_W-1:0]    frd, drd, px_c;
	logic                hidden_c;
	logic [15:0]         cm_s1 [3];
	logic [15:0]         bm_s1 [3];
	logic [7:0]          blend_c [3];

	logic                f_we, d_we;
	logic [ADDR_W-1:0]   waddr;
	logic [PIX_W-1:0]    f_wdata, d_wdata;

	logic [1:0]          res_status_q;
	logic [IDX_W-1:0]    res_index_q;
	logic [PIX_W-1:0]    res_value_q;

	assign w_eff = (cfg_width > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : cfg_width;
	assign h_eff = (cfg_height > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : cfg_height;

	// Too near when the raw depth is at or below 0.1 in Q16.16.
	assign stat.near     = (z_depth <= NEAR_LIMIT);
	assign stat.clr_done = (clr_cnt_q == ADDR_W'(STORE_WORDS - 1));

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			x_q      <= x_pos;
			y_q      <= y_pos;
			z_q      <= z_depth;
			col_q[0] <= red;
			col_q[1] <= green;
			col_q[2] <= blue;
			a_q      <= alpha;
		end
		if (cmd.mul) begin
			xs_s1 <= MAG_W'(x_q) * MAG_W'($signed({1'b0, cfg_scale}));
			ys_s1 <= MAG_W'(y_q) * MAG_W'($signed({1'b0, cfg_scale}));
			wz_s1 <= MAG_W'($signed({1'b0, w_eff[DIM_W-1:1]})) * MAG_W'(z_q);
			hz_s1 <= MAG_W'($signed({1'b0, h_eff[DIM_W-1:1]})) * MAG_W'(z_q);
		end
		if (cmd.sum) begin
			numc_s2 <= NUM_W'(wz_s1) + NUM_W'(xs_s1);
			numr_s2 <= NUM_W'(hz_s1) - NUM_W'(ys_s1);
		end
	end

	// Restoring division of the numerator magnitudes by z, one bit a step.
	assign z_ext   = {1'b0, z_q};
	assign remc_sh = {remc_q, dvdc_q[MAG_W-1]};
	assign remr_sh = {remr_q, dvdr_q[MAG_W-1]};
	assign gec     = (remc_sh >= z_ext);
	assign ger     = (remr_sh >= z_ext);

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			negc_q <= numc_s2[NUM_W-1];
			negr_q <= numr_s2[NUM_W-1];
			dvdc_q <= MAG_W'(numc_s2[NUM_W-1] ? -numc_s2 : numc_s2);
			dvdr_q <= MAG_W'(numr_s2[NUM_W-1] ? -numr_s2 : numr_s2);
			remc_q <= '0;
			remr_q <= '0;
		end else if (cmd.div_step) begin
			remc_q <= COORD_W'(gec ? (remc_sh - z_ext) : remc_sh);
			remr_q <= COORD_W'(ger ? (remr_sh - z_ext) : remr_sh);
			dvdc_q <= {dvdc_q[MAG_W-2:0], gec};
			dvdr_q <= {dvdr_q[MAG_W-2:0], ger};
		end
	end

	// A negative quotient only lands on the surface when it truncates to zero.
	assign in_col = (!negc_q || dvdc_q == '0) && (dvdc_q < MAG_W'(w_eff));
	assign in_row = (!negr_q || dvdr_q == '0) && (dvdr_q < MAG_W'(h_eff));
	assign stat.off = !(in_col && in_row);
	assign col_c  = dvdc_q[COL_W-1:0];
	assign row_c  = dvdr_q[ROW_W-1:0];
	assign rw_c   = RW_W'(row_c) * RW_W'(w_eff);
	assign idx_c  = ADDR_W'(rw_c + RW_W'(col_c));

	assign hidden_c   = cfg_depth_en && !(drd > PIX_W'(z_q));
	assign stat.hidden = hidden_c;

	for (genvar c = 0; c < 3; c++) begin : g_blend
		logic [15:0] v;
		logic [16:0] t;
		assign v = cm_s1[c] + bm_s1[c];
		assign t = (17'(v) + 17'd1 + 17'(v >> 8)) >> 8;
		assign blend_c[c] = t[7:0];

		always_ff @(posedge clk) begin
			if (cmd.test) begin
				cm_s1[c] <= 16'(col_q[c]) * 16'(a_q);
				bm_s1[c] <= 16'(frd[8*c +: 8]) * 16'(8'd255 - a_q);
			end
		end
	end
	assign px_c = {8'hFF, blend_c[2], blend_c[1], blend_c[0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.idx) begin
			idx_q <= idx_c;
		end
	end

	assign waddr   = cmd.clr ? clr_cnt_q : idx_q;
	assign f_we    = cmd.clr || cmd.commit;
	assign d_we    = cmd.clr || (cmd.commit && cfg_depth_en);
	assign f_wdata = cmd.clr ? '0 : px_c;
	assign d_wdata = cmd.clr ? '1 : PIX_W'(z_q);

	ppdb_ram #(.WIDTH(PIX_W), .DEPTH(STORE_WORDS)) u_frame (
		.clk   (clk),
		.we    (f_we),
		.waddr (waddr),
		.wdata (f_wdata),
		.raddr (idx_q),
		.rdata (frd)
	);

	ppdb_ram #(.WIDTH(PIX_W), .DEPTH(STORE_WORDS)) u_depth (
		.clk   (clk),
		.we    (d_we),
		.waddr (waddr),
		.wdata (d_wdata),
		.raddr (idx_q),
		.rdata (drd)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			res_status_q <= stat.near ? ST_NEAR : ST_WRITTEN;
			res_index_q  <= '0;
			res_value_q  <= '0;
		end
		if (cmd.idx) begin
			if (stat.off) begin
				res_status_q <= ST_OFF;
			end else begin
				res_index_q <= IDX_W'(idx_c);
			end
		end
		if (cmd.test && hidden_c) begin
			res_status_q <= ST_HIDDEN;
			res_value_q  <= frd;
		end
		if (cmd.commit) begin
			res_value_q <= px_c;
		end
		if (cmd.res_load) begin
			status      <= res_status_q;
			pixel_index <= res_index_q;
			pixel_value <= res_value_q;
		end
	end
endmodule
